// File: sv/ght_pkg.sv
// Shared constants and operation and status codes for the generational handle table.
package ght_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int GEN_W = 32;
	localparam int HANDLE_W = 64;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_OUT_W = 6;

	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_VALIDATE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

// File: sv/generational_handle_table.sv
// Generational handle table: live flags in registers, generation counters in a synchronous RAM.
// Each transaction reads the RAM in the cycle of acceptance, then checks and writes back in execute.
// One transaction is in flight at a time; execute stalls while an untaken result is held.
// The result register lets the next transaction be accepted while a result waits to be taken.
// Reset clears all live flags and per-slot written bits; an unwritten generation reads as zero.
module generational_handle_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ght_pkg::FUNC_W-1:0]    func,
	input  logic [ght_pkg::HANDLE_W-1:0]  handle_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ght_pkg::STATUS_W-1:0]  status,
	output logic [ght_pkg::HANDLE_W-1:0]  handle_out,
	output logic [ght_pkg::SLOT_OUT_W-1:0] slot_index
);
	import ght_pkg::*;

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                 state_q;
	logic [SLOT_COUNT-1:0]  live_q;
	logic [SLOT_COUNT-1:0]  written_q;
	logic [FUNC_W-1:0]      func_s1;
	logic [GEN_W-1:0]       hgen_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic                   hit_s1;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [HANDLE_W-1:0]    handle_q;
	logic [SLOT_OUT_W-1:0]  slot_q;

	logic [GEN_W-1:0]       gen_mem [SLOT_COUNT];
	logic [GEN_W-1:0]       gen_rdata_q;

	logic                   accept;
	logic                   done;
	logic                   found;
	logic [SLOT_W-1:0]      free_idx;
	logic [GEN_W-1:0]       slot_field;
	logic                   in_range;
	logic [SLOT_W-1:0]      h_idx;
	logic [SLOT_W-1:0]      rd_addr;
	logic                   hit_now;
	logic [GEN_W-1:0]       cur_gen;
	logic                   gen_match;
	logic                   free_ok;
	logic                   alloc_ok;
	logic [STATUS_W-1:0]    res_status;
	logic [HANDLE_W-1:0]    res_handle;
	logic [SLOT_OUT_W-1:0]  res_slot;

	always_comb begin
		found = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				found = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign slot_field = handle_in[GEN_W-1:0];
	assign in_range = (slot_field != '0) && (slot_field <= GEN_W'(SLOT_COUNT));
	assign h_idx = SLOT_W'(slot_field - GEN_W'(1));
	assign rd_addr = (func == FN_ALLOC) ? free_idx : h_idx;
	assign hit_now = (func == FN_ALLOC) ? found : (in_range && live_q[h_idx]);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign done = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	assign cur_gen = written_q[slot_s1] ? gen_rdata_q : '0;
	assign gen_match = hit_s1 && (cur_gen == hgen_s1);
	assign alloc_ok = (func_s1 == FN_ALLOC) && hit_s1;
	assign free_ok = (func_s1 == FN_FREE) && gen_match;

	always_comb begin
		res_status = ST_BAD_HANDLE;
		res_handle = '0;
		res_slot = '0;
		case (func_s1)
			FN_ALLOC: begin
				if (alloc_ok) begin
					res_status = ST_OK;
					res_handle = {cur_gen, GEN_W'(slot_s1) + GEN_W'(1)};
					res_slot = SLOT_OUT_W'(slot_s1);
				end else begin
					res_status = ST_FULL;
				end
			end
			FN_FREE: begin
				if (free_ok) begin
					res_status = ST_OK;
					res_slot = SLOT_OUT_W'(slot_s1);
				end
			end
			FN_VALIDATE: begin
				if (gen_match) begin
					res_status = ST_OK;
					res_slot = SLOT_OUT_W'(slot_s1);
				end
			end
			default: begin
				res_status = ST_BAD_HANDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gen_rdata_q <= gen_mem[rd_addr];
		end
		if (done && free_ok) begin
			gen_mem[slot_s1] <= cur_gen + GEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			live_q <= '0;
			written_q <= '0;
			func_s1 <= FN_ALLOC;
			hgen_s1 <= '0;
			slot_s1 <= '0;
			hit_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= ST_OK;
			handle_q <= '0;
			slot_q <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_s1 <= func;
						hgen_s1 <= handle_in[HANDLE_W-1:GEN_W];
						slot_s1 <= rd_addr;
						hit_s1 <= hit_now;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						status_q <= res_status;
						handle_q <= res_handle;
						slot_q <= res_slot;
						if (alloc_ok) begin
							live_q[slot_s1] <= 1'b1;
						end
						if (free_ok) begin
							live_q[slot_s1] <= 1'b0;
							written_q[slot_s1] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign handle_out = handle_q;
	assign slot_index = slot_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("An accepted transaction did not enter the execute state.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_OK)) |-> ((handle_q == '0) && (slot_q == '0)))
		else $error("A failed transaction returned a nonzero handle or slot.");

	a_alloc_live: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alloc_ok) |=> live_q[$past(slot_s1)])
		else $error("An allocated slot was not marked live.");

	a_free_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(done && free_ok) |=> (!live_q[$past(slot_s1)] && written_q[$past(slot_s1)]))
		else $error("A freed slot was left live or its generation unmarked.");

	a_alloc_was_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && alloc_ok) |-> !live_q[slot_s1])
		else $error("Allocation chose a slot that is already live.");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the generational handle table, with a built-in slot table predictor.
module testbench;
	import ght_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 550;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [HANDLE_W-1:0]   handle;
		logic [SLOT_OUT_W-1:0] slot;
	} reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func = '0;
	logic [HANDLE_W-1:0]   handle_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [HANDLE_W-1:0]   handle_out;
	logic [SLOT_OUT_W-1:0] slot_index;

	logic [SLOT_COUNT-1:0] model_live;
	logic [GEN_W-1:0]      model_gen [SLOT_COUNT];
	reply_t                pending_replies [$];
	int                    send_gap_pct = 20;
	int                    take_gap_pct = 20;
	int                    failures = 0;
	int                    cycle_count = 0;

	generational_handle_table u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.handle_out (handle_out),
		.slot_index (slot_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
	end

	function automatic bit handle_ok(input logic [HANDLE_W-1:0] h, output int idx);
		logic [31:0] s;
		s = h[31:0];
		idx = 0;
		if (s == 0 || s > SLOT_COUNT)
			return 1'b0;
		idx = int'(s) - 1;
		return model_live[idx] && (h[63:32] == model_gen[idx]);
	endfunction

	function automatic logic [HANDLE_W-1:0] handle_of(input int idx);
		return {model_gen[idx], 32'(idx + 1)};
	endfunction

	// Applies one operation to the predicted table and returns the reply it must give.
	function automatic reply_t apply_op(input logic [FUNC_W-1:0] f, input logic [HANDLE_W-1:0] h);
		reply_t r;
		int     idx;
		r = '0;
		r.status = ST_BAD_HANDLE;
		case (f)
			FN_ALLOC: begin
				idx = -1;
				for (int i = SLOT_COUNT - 1; i >= 0; i--)
					if (!model_live[i])
						idx = i;
				r.status = ST_FULL;
				if (idx >= 0) begin
					model_live[idx] = 1'b1;
					r.status = ST_OK;
					r.handle = handle_of(idx);
					r.slot = SLOT_OUT_W'(idx);
				end
			end
			FN_FREE: begin
				if (handle_ok(h, idx)) begin
					model_gen[idx] = model_gen[idx] + 1'b1;
					model_live[idx] = 1'b0;
					r.status = ST_OK;
					r.slot = SLOT_OUT_W'(idx);
				end
			end
			FN_VALIDATE: begin
				if (handle_ok(h, idx)) begin
					r.status = ST_OK;
					r.slot = SLOT_OUT_W'(idx);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int pick_live();
		int start;
		start = $urandom_range(SLOT_COUNT - 1);
		for (int k = 0; k < SLOT_COUNT; k++)
			if (model_live[(start + k) % SLOT_COUNT])
				return (start + k) % SLOT_COUNT;
		return -1;
	endfunction

	function automatic void check_reply(input reply_t want);
		if (status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, status);
			failures++;
		end
		if (handle_out !== want.handle) begin
			$error("handle_out: expected %h, got %h", want.handle, handle_out);
			failures++;
		end
		if (slot_index !== want.slot) begin
			$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
			failures++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected transaction: status %0d, handle_out %h, slot_index %0d",
					status, handle_out, slot_index);
				failures++;
			end else begin
				check_reply(pending_replies.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= take_gap_pct);
	end

	task automatic send_op(input logic [FUNC_W-1:0] f, input logic [HANDLE_W-1:0] h);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		handle_in <= h;
		do @(posedge clk); while (!in_ready);
		pending_replies.push_back(apply_op(f, h));
		@(negedge clk);
	endtask

	// The generation wrap needs 2^32 frees of one slot and lies beyond a run of this length.
	task automatic test_directed();
		send_op(FN_VALIDATE, '0);
		send_op(FN_FREE, '0);
		send_op(FN_VALIDATE, handle_of(0));
		send_op(FN_ALLOC, '1);
		send_op(FN_VALIDATE, handle_of(0));
		send_op(FN_VALIDATE, handle_of(0) ^ (64'h1 << 32));
		send_op(FN_VALIDATE, {32'h0, 32'(SLOT_COUNT + 1)});
		send_op(FN_VALIDATE, {32'h0, 32'hFFFF_FFFF});
		send_op(FN_VALIDATE, '1);
		send_op(FN_UNUSED, handle_of(0));
		send_op(FN_UNUSED, '1);
		send_op(FN_VALIDATE, handle_of(0));
		send_op(FN_FREE, handle_of(0));
		send_op(FN_FREE, {32'h0, 32'd1});
		send_op(FN_VALIDATE, {32'h0, 32'd1});
		send_op(FN_ALLOC, '0);
		send_op(FN_VALIDATE, handle_of(0));
		send_op(FN_ALLOC, 64'hA5A5_5A5A_C3C3_3C3C);
		send_op(FN_FREE, {32'hFFFF_FFFF, 32'd2});
		send_op(FN_FREE, handle_of(1));
		send_op(FN_VALIDATE, {32'h0, 32'(SLOT_COUNT)});
	endtask

	task automatic test_table_full();
		while (model_live != '1)
			send_op(FN_ALLOC, {$urandom, $urandom});
		send_op(FN_ALLOC, '0);
		send_op(FN_ALLOC, '1);
		send_op(FN_VALIDATE, handle_of(SLOT_COUNT - 1));
		send_op(FN_FREE, handle_of(SLOT_COUNT - 1));
		send_op(FN_FREE, handle_of(17));
		send_op(FN_ALLOC, '0);
		send_op(FN_ALLOC, '0);
		// Hold the sender back until every outstanding transaction has been answered.
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		for (int i = 0; i < SLOT_COUNT; i++)
			send_op(FN_FREE, handle_of(i));
	endtask

	task automatic test_random_churn();
		int                  idx;
		int                  pick;
		int                  s;
		logic [FUNC_W-1:0]   op;
		logic [HANDLE_W-1:0] h;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 4) begin
				send_gap_pct = 0;
				take_gap_pct = 0;
			end
			if (n == RANDOM_ITEMS / 2) begin
				send_gap_pct = 20;
				take_gap_pct = 20;
			end
			idx = pick_live();
			pick = $urandom_range(99);
			h = {$urandom, $urandom};
			op = $urandom_range(1) ? FN_FREE : FN_VALIDATE;
			s = $urandom_range(SLOT_COUNT - 1);
			if (pick < (($countones(model_live) > 48) ? 25 : 40)) begin
				send_op(FN_ALLOC, h);
			end else if (idx < 0 || pick >= 85) begin
				case ($urandom_range(4))
					0: send_op(FN_UNUSED, h);
					1: send_op(op, h);
					2: send_op(op, {model_gen[s] - 1'b1, 32'(s + 1)});
					3: send_op(op, {h[63:32], 32'($urandom_range(SLOT_COUNT))});
					default: send_op(op, {model_gen[s], 32'(SLOT_COUNT + 1 + $urandom_range(7))});
				endcase
			end else if (pick < 70) begin
				send_op(FN_FREE, handle_of(idx));
			end else begin
				send_op(FN_VALIDATE, handle_of(idx));
			end
		end
	endtask

	initial begin
		model_live = '0;
		foreach (model_gen[i])
			model_gen[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_table_full();
		test_random_churn();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

endmodule
